/* hw/rtl/wprs_pkg.sv */
// Shared types and constants of the wraparound pan rectangle splitter.
package wprs_pkg;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned RECT_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SRC_WIDTH   = 3'd0,
    CFG_SRC_HEIGHT  = 3'd1,
    CFG_AREA_LEFT   = 3'd2,
    CFG_AREA_TOP    = 3'd3,
    CFG_VIEW_WIDTH  = 3'd4,
    CFG_VIEW_HEIGHT = 3'd5,
    CFG_X_SPEED     = 3'd6,
    CFG_Y_SPEED     = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    RK_FULL,
    RK_SPLIT_A,
    RK_SPLIT_B,
    RK_CORNER,
    RK_LOWER,
    RK_UPPER
  } rect_kind_e;

  typedef struct packed {
    logic vsplit;
    logic hsplit;
  } seam_t;

  localparam int unsigned SEAM_BITS = $bits(seam_t);

endpackage

/* hw/rtl/wraparound_pan_rect_splitter_top.sv */
// Top level of the wraparound pan rectangle splitter: configuration and wiring.
//
// Each accepted tick with frame_tick_i set moves the source offset by the negated
// speeds, wraps it into the source image and yields one, two or four copy
// rectangles, the last flagged by last_rect_o. A tick with frame_tick_i clear is
// taken and dropped. The front end wraps each offset with its own bit-serial
// remainder unit and holds full high from an accepted tick until its job has
// entered the queue. Jobs wait in a two-entry queue, and the back end delivers
// one rectangle per cycle from its output register while pop is held and the
// queue holds jobs, so it works on earlier ticks while the front end computes
// the next one. Configuration writes are always taken and belong to idle
// periods.
module wraparound_pan_rect_splitter_top #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wprs_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,
  input  logic                              push,
  output logic                              full,
  input  logic                              frame_tick_i,
  input  logic                              pop,
  output logic                              empty,
  output logic [COORD_BITS-1:0]             src_left_o,
  output logic [COORD_BITS-1:0]             src_top_o,
  output logic [COORD_BITS-1:0]             src_right_o,
  output logic [COORD_BITS-1:0]             src_bottom_o,
  output logic [COORD_BITS-1:0]             dst_left_o,
  output logic [COORD_BITS-1:0]             dst_top_o,
  output logic [COORD_BITS-1:0]             dst_right_o,
  output logic [COORD_BITS-1:0]             dst_bottom_o,
  output logic                              last_rect_o
);

  import wprs_pkg::*;

  localparam int unsigned JOB_BITS    = 4 * COORD_BITS + SEAM_BITS;
  localparam int unsigned QUEUE_DEPTH = 2;

  logic [COORD_BITS-1:0]        src_width_q, src_height_q, area_left_q, area_top_q;
  logic [COORD_BITS-1:0]        view_width_q, view_height_q;
  logic signed [COORD_BITS-1:0] x_speed_q, y_speed_q;

  logic                q_push, q_full, q_pop, q_empty;
  logic [JOB_BITS-1:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q   <= COORD_BITS'(1);
      src_height_q  <= COORD_BITS'(1);
      area_left_q   <= '0;
      area_top_q    <= '0;
      view_width_q  <= COORD_BITS'(1);
      view_height_q <= COORD_BITS'(1);
      x_speed_q     <= '0;
      y_speed_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SRC_WIDTH:   src_width_q   <= cfg_data_i;
        CFG_SRC_HEIGHT:  src_height_q  <= cfg_data_i;
        CFG_AREA_LEFT:   area_left_q   <= cfg_data_i;
        CFG_AREA_TOP:    area_top_q    <= cfg_data_i;
        CFG_VIEW_WIDTH:  view_width_q  <= cfg_data_i;
        CFG_VIEW_HEIGHT: view_height_q <= cfg_data_i;
        CFG_X_SPEED:     x_speed_q     <= cfg_data_i;
        CFG_Y_SPEED:     y_speed_q     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  wprs_front #(.W(COORD_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .tick_i        (frame_tick_i),
    .full_o        (full),
    .src_width_i   (src_width_q),
    .src_height_i  (src_height_q),
    .view_width_i  (view_width_q),
    .view_height_i (view_height_q),
    .x_speed_i     (x_speed_q),
    .y_speed_i     (y_speed_q),
    .q_push_o      (q_push),
    .q_full_i      (q_full),
    .q_data_o      (q_wdata)
  );

  wprs_queue #(.WIDTH(JOB_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  wprs_back #(.W(COORD_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_data_i      (q_rdata),
    .q_pop_o       (q_pop),
    .area_left_i   (area_left_q),
    .area_top_i    (area_top_q),
    .view_width_i  (view_width_q),
    .view_height_i (view_height_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .src_left_o    (src_left_o),
    .src_top_o     (src_top_o),
    .src_right_o   (src_right_o),
    .src_bottom_o  (src_bottom_o),
    .dst_left_o    (dst_left_o),
    .dst_top_o     (dst_top_o),
    .dst_right_o   (dst_right_o),
    .dst_bottom_o  (dst_bottom_o),
    .last_rect_o   (last_rect_o)
  );

endmodule

/* hw/rtl/wprs_wrap_div.sv */
// Bit-serial wrap of (pos - speed) into 0..size-1, one quotient bit per cycle.
module wprs_wrap_div #(
  parameter int unsigned W = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        pos_i,
  input  logic signed [W-1:0] speed_i,
  input  logic [W-1:0]        size_i,
  output logic                done_o,
  output logic [W-1:0]        rem_o
);

  localparam int unsigned MW = W + 1;
  localparam int unsigned CW = $clog2(W + 2);

  logic          run_q, fix_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, m_q;
  logic [MW-1:0] mag_q;
  logic          neg_q;

  logic [W+1:0]  diff, diff_neg;
  logic [MW-1:0] mag;
  logic [W:0]    trial, trial_sub;
  logic [W-1:0]  rem_next;

  assign diff     = {2'b00, pos_i} - {{2{speed_i[W-1]}}, speed_i};
  assign diff_neg = (W+2)'(0) - diff;
  assign mag      = diff[W+1] ? diff_neg[W:0] : diff[W:0];

  assign trial     = {rem_q, mag_q[MW-1]};
  assign trial_sub = trial - {1'b0, m_q};
  assign rem_next  = (trial >= {1'b0, m_q}) ? trial_sub[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fix_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      fix_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(MW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          fix_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      mag_q <= mag;
      neg_q <= diff[W+1];
      m_q   <= size_i;
    end else if (run_q) begin
      rem_q <= rem_next;
      mag_q <= {mag_q[MW-2:0], 1'b0};
    end
  end

  // negative dividend: fold the magnitude remainder back into range
  assign done_o = fix_q;
  assign rem_o  = (neg_q && (rem_q != '0)) ? (m_q - rem_q) : rem_q;

endmodule

/* hw/rtl/wprs_queue.sv */
// Small job queue between the offset front end and the rectangle emitter.
module wprs_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [AW:0]      count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/wprs_front.sv */
// Front end: takes ticks, advances the wrapped offsets and classifies the seams.
module wprs_front #(
  parameter int unsigned W = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic                    tick_i,
  output logic                    full_o,
  input  logic [W-1:0]            src_width_i,
  input  logic [W-1:0]            src_height_i,
  input  logic [W-1:0]            view_width_i,
  input  logic [W-1:0]            view_height_i,
  input  logic signed [W-1:0]     x_speed_i,
  input  logic signed [W-1:0]     y_speed_i,
  output logic                    q_push_o,
  input  logic                    q_full_i,
  output logic [4*W+wprs_pkg::SEAM_BITS-1:0] q_data_o
);

  import wprs_pkg::*;

  front_state_e state_q, state_d;
  logic [W-1:0] offset_x_q, offset_y_q;
  logic [W-1:0] w_eff, h_eff, x_room, y_room, xb, yb, rem_x, rem_y;
  logic         start, done_x, done_y, done;
  seam_t        seam;

  assign w_eff = (src_width_i == '0) ? W'(1) : src_width_i;
  assign h_eff = (src_height_i == '0) ? W'(1) : src_height_i;

  wprs_wrap_div #(.W(W)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .pos_i   (offset_x_q),
    .speed_i (x_speed_i),
    .size_i  (w_eff),
    .done_o  (done_x),
    .rem_o   (rem_x)
  );

  wprs_wrap_div #(.W(W)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .pos_i   (offset_y_q),
    .speed_i (y_speed_i),
    .size_i  (h_eff),
    .done_o  (done_y),
    .rem_o   (rem_y)
  );

  // both axes start together and take the same number of steps
  assign done = done_x && done_y;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE: if (push_i && tick_i) state_d = FS_DIV;
      FS_DIV:  if (done) state_d = FS_PUSH;
      FS_PUSH: if (!q_full_i) state_d = FS_IDLE;
      default: state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    full_o   = (state_q != FS_IDLE);
    start    = (state_q == FS_IDLE) && push_i && tick_i;
    q_push_o = (state_q == FS_PUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_IDLE;
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FS_DIV && done) begin
        offset_x_q <= rem_x;
        offset_y_q <= rem_y;
      end
    end
  end

  // room never underflows while offsets lie below the current source size
  assign x_room = w_eff - offset_x_q;
  assign y_room = h_eff - offset_y_q;
  assign xb     = (x_room >= view_width_i) ? view_width_i : x_room;
  assign yb     = (y_room >= view_height_i) ? view_height_i : y_room;

  always_comb begin
    seam.vsplit = (xb != view_width_i);
    seam.hsplit = (yb != view_height_i);
  end

  assign q_data_o = {seam, offset_x_q, offset_y_q, xb, yb};

endmodule

/* hw/rtl/wprs_back.sv */
// Back end: walks each job's rectangles and holds one in the output register.
module wprs_back #(
  parameter int unsigned W = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_empty_i,
  input  logic [4*W+wprs_pkg::SEAM_BITS-1:0] q_data_i,
  output logic                    q_pop_o,
  input  logic [W-1:0]            area_left_i,
  input  logic [W-1:0]            area_top_i,
  input  logic [W-1:0]            view_width_i,
  input  logic [W-1:0]            view_height_i,
  input  logic                    pop_i,
  output logic                    empty_o,
  output logic [W-1:0]            src_left_o,
  output logic [W-1:0]            src_top_o,
  output logic [W-1:0]            src_right_o,
  output logic [W-1:0]            src_bottom_o,
  output logic [W-1:0]            dst_left_o,
  output logic [W-1:0]            dst_top_o,
  output logic [W-1:0]            dst_right_o,
  output logic [W-1:0]            dst_bottom_o,
  output logic                    last_rect_o
);

  import wprs_pkg::*;

  seam_t                    seam;
  logic [W-1:0]             x, y, xb, yb;
  logic [RECT_IDX_BITS-1:0] idx_q, last_idx;
  rect_kind_e               kind;
  logic                     out_valid_q, load, is_last;
  logic [W-1:0]             sl, st, sr, sb, dl, dt, dr, db;
  logic [W-1:0]             r_edge, b_edge, l_xb, t_yb;

  assign {seam, x, y, xb, yb} = q_data_i;

  assign r_edge = area_left_i + view_width_i;
  assign b_edge = area_top_i + view_height_i;
  assign l_xb   = area_left_i + xb;
  assign t_yb   = area_top_i + yb;

  always_comb begin
    kind     = RK_FULL;
    last_idx = RECT_IDX_BITS'(0);
    unique case ({seam.vsplit, seam.hsplit})
      2'b11: begin
        last_idx = RECT_IDX_BITS'(3);
        unique case (idx_q)
          2'd0:    kind = RK_SPLIT_A;
          2'd1:    kind = RK_SPLIT_B;
          2'd2:    kind = RK_CORNER;
          default: kind = RK_LOWER;
        endcase
      end
      2'b10: begin
        last_idx = RECT_IDX_BITS'(1);
        kind     = (idx_q == '0) ? RK_SPLIT_A : RK_SPLIT_B;
      end
      2'b01: begin
        last_idx = RECT_IDX_BITS'(1);
        kind     = (idx_q == '0) ? RK_UPPER : RK_LOWER;
      end
      default: begin
        last_idx = RECT_IDX_BITS'(0);
        kind     = RK_FULL;
      end
    endcase
  end

  always_comb begin
    sl = x;
    st = y;
    sr = x + view_width_i;
    sb = y + view_height_i;
    dl = area_left_i;
    dt = area_top_i;
    dr = r_edge;
    db = b_edge;
    unique case (kind)
      RK_FULL: begin
      end
      RK_SPLIT_A: begin
        sr = x + xb;
        sb = y + yb;
        dr = l_xb;
        db = t_yb;
      end
      RK_SPLIT_B: begin
        sl = '0;
        sr = view_width_i - xb;
        sb = y + yb;
        dl = l_xb;
        db = t_yb;
      end
      RK_CORNER: begin
        sl = '0;
        st = '0;
        sr = view_width_i - xb;
        sb = view_height_i - yb;
        dl = l_xb;
        dt = t_yb;
      end
      RK_LOWER: begin
        st = '0;
        sr = x + xb;
        sb = view_height_i - yb;
        dt = t_yb;
        dr = l_xb;
      end
      RK_UPPER: begin
        sb = y + yb;
        dr = l_xb;
        db = t_yb;
      end
      default: begin
      end
    endcase
  end

  assign load    = !q_empty_i && (!out_valid_q || pop_i);
  assign is_last = (idx_q == last_idx);
  assign q_pop_o = load && is_last;
  assign empty_o = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + RECT_IDX_BITS'(1);
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      src_left_o   <= sl;
      src_top_o    <= st;
      src_right_o  <= sr;
      src_bottom_o <= sb;
      dst_left_o   <= dl;
      dst_top_o    <= dt;
      dst_right_o  <= dr;
      dst_bottom_o <= db;
      last_rect_o  <= is_last;
    end
  end

endmodule
